// ===== src/ucm_pkg.sv =====
// ----------------------------------------------------------------------------
// ucm_pkg
// shared types, case mode codes, range tables and the simple case map
// ----------------------------------------------------------------------------
package ucm_pkg;

    localparam int CP_W = 21;

    typedef logic [CP_W-1:0] t_cp;

    typedef enum logic [1:0] {
        MODE_UPPER      = 2'd0,
        MODE_LOWER      = 2'd1,
        MODE_TITLE      = 2'd2,
        MODE_CAPITALIZE = 2'd3
    } t_case_mode;

    typedef struct packed {
        t_cp  code_point;
        logic map_en;
        logic up;
        logic is_letter;
        logic is_num;
        logic is_cased;
    } t_item;

    typedef struct packed {
        t_cp lo;
        t_cp hi;
    } t_span;

    localparam int N_DIGIT  = 21;
    localparam int N_LETTER = 45;

    localparam t_span DIGIT_SPANS [N_DIGIT] = '{
        '{21'h0030, 21'h0039}, '{21'h0660, 21'h0669}, '{21'h06F0, 21'h06F9},
        '{21'h07C0, 21'h07C9}, '{21'h0966, 21'h096F}, '{21'h09E6, 21'h09EF},
        '{21'h0A66, 21'h0A6F}, '{21'h0AE6, 21'h0AEF}, '{21'h0B66, 21'h0B6F},
        '{21'h0BE6, 21'h0BEF}, '{21'h0C66, 21'h0C6F}, '{21'h0CE6, 21'h0CEF},
        '{21'h0D66, 21'h0D6F}, '{21'h0E50, 21'h0E59}, '{21'h0ED0, 21'h0ED9},
        '{21'h0F20, 21'h0F29}, '{21'h1040, 21'h1049}, '{21'h17E0, 21'h17E9},
        '{21'h1810, 21'h1819}, '{21'hFF10, 21'hFF19}, '{21'h1D7CE, 21'h1D7FF}
    };

    localparam t_span LETTER_SPANS [N_LETTER] = '{
        '{21'h00AA, 21'h00AA}, '{21'h00BA, 21'h00BA}, '{21'h01BB, 21'h01BB},
        '{21'h01C0, 21'h01C3}, '{21'h0294, 21'h0294}, '{21'h02B0, 21'h02C1},
        '{21'h0370, 21'h0374}, '{21'h037A, 21'h037A}, '{21'h03F7, 21'h03FB},
        '{21'h0559, 21'h0559}, '{21'h05D0, 21'h05EA}, '{21'h05EF, 21'h05F2},
        '{21'h0620, 21'h064A}, '{21'h066E, 21'h066F}, '{21'h0671, 21'h06D3},
        '{21'h06D5, 21'h06D5}, '{21'h0710, 21'h072F}, '{21'h0904, 21'h0939},
        '{21'h093D, 21'h093D}, '{21'h0950, 21'h0950}, '{21'h0958, 21'h0961},
        '{21'h0985, 21'h098C}, '{21'h0993, 21'h09A8}, '{21'h09AA, 21'h09B0},
        '{21'h0A05, 21'h0A0A}, '{21'h0B05, 21'h0B0C}, '{21'h0C05, 21'h0C0C},
        '{21'h0D05, 21'h0D0C}, '{21'h0E01, 21'h0E30}, '{21'h0E32, 21'h0E33},
        '{21'h0E40, 21'h0E46}, '{21'h1100, 21'h11FF}, '{21'h1200, 21'h1248},
        '{21'h3005, 21'h3006}, '{21'h3041, 21'h3096}, '{21'h309D, 21'h309F},
        '{21'h30A1, 21'h30FA}, '{21'h30FC, 21'h30FF}, '{21'h3400, 21'h4DBF},
        '{21'h4E00, 21'h9FFF}, '{21'hA000, 21'hA48C}, '{21'hAC00, 21'hD7A3},
        '{21'hF900, 21'hFA6D}, '{21'hFF66, 21'hFFDC}, '{21'h20000, 21'h2A6DF}
    };

    function automatic logic in_digit(input t_cp c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < N_DIGIT; i++) begin
            if (c >= DIGIT_SPANS[i].lo && c <= DIGIT_SPANS[i].hi) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic in_letter(input t_cp c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < N_LETTER; i++) begin
            if (c >= LETTER_SPANS[i].lo && c <= LETTER_SPANS[i].hi) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // capital at even code, small at odd
    function automatic t_cp pair_even(input t_cp c, input logic up);
        if (up) begin
            return c[0] ? c - 21'd1 : c;
        end
        return c[0] ? c : c + 21'd1;
    endfunction

    // capital at odd code, small at even
    function automatic t_cp pair_odd(input t_cp c, input logic up);
        if (up) begin
            return c[0] ? c : c - 21'd1;
        end
        return c[0] ? c + 21'd1 : c;
    endfunction

    function automatic t_cp map_one(input t_cp c, input logic up);
        if (c < 21'h80) begin
            if (up) begin
                return (c >= 21'h61 && c <= 21'h7A) ? c - 21'd32 : c;
            end
            return (c >= 21'h41 && c <= 21'h5A) ? c + 21'd32 : c;
        end
        if (c < 21'h100) begin
            if (c == 21'hB5) return up ? 21'h39C : c;
            if (c == 21'hFF) return up ? 21'h178 : c;
            if (c == 21'hDF) return c;
            if (c >= 21'hC0 && c <= 21'hDE && c != 21'hD7) return up ? c : c + 21'd32;
            if (c >= 21'hE0 && c <= 21'hFE && c != 21'hF7) return up ? c - 21'd32 : c;
            return c;
        end
        if (c <= 21'h17F) begin
            if (c == 21'h130) return up ? c : 21'h69;
            if (c == 21'h131) return up ? 21'h49 : c;
            if (c == 21'h138 || c == 21'h149) return c;
            if (c == 21'h17F) return up ? 21'h53 : c;
            if (c == 21'h178) return up ? c : 21'hFF;
            if (c <= 21'h137 || (c >= 21'h14A && c <= 21'h177)) return pair_even(c, up);
            return pair_odd(c, up);
        end
        if (c <= 21'h24F) begin
            if (c >= 21'h1CD && c <= 21'h1DC) return pair_odd(c, up);
            if (c >= 21'h1DE && c <= 21'h1EF) return pair_even(c, up);
            if (c >= 21'h1F8 && c <= 21'h21F) return pair_even(c, up);
            if (c >= 21'h222 && c <= 21'h233) return pair_even(c, up);
            if (c >= 21'h246 && c <= 21'h24F) return pair_even(c, up);
            return c;
        end
        if (c >= 21'h386 && c <= 21'h3CE) begin
            if (c == 21'h386) return up ? c : 21'h3AC;
            if (c >= 21'h388 && c <= 21'h38A) return up ? c : c + 21'h25;
            if (c == 21'h38C) return up ? c : 21'h3CC;
            if (c == 21'h38E || c == 21'h38F) return up ? c : c + 21'h3F;
            if (c >= 21'h391 && c <= 21'h3AB && c != 21'h3A2) return up ? c : c + 21'h20;
            if (c == 21'h3AC) return up ? 21'h386 : c;
            if (c >= 21'h3AD && c <= 21'h3AF) return up ? c - 21'h25 : c;
            if (c == 21'h3C2) return up ? 21'h3A3 : c;
            if (c >= 21'h3B1 && c <= 21'h3CB) return up ? c - 21'h20 : c;
            if (c == 21'h3CC) return up ? 21'h38C : c;
            if (c == 21'h3CD || c == 21'h3CE) return up ? c - 21'h3F : c;
            return c;
        end
        if (c >= 21'h400 && c <= 21'h52F) begin
            if (c <= 21'h40F) return up ? c : c + 21'h50;
            if (c <= 21'h42F) return up ? c : c + 21'h20;
            if (c <= 21'h44F) return up ? c - 21'h20 : c;
            if (c <= 21'h45F) return up ? c - 21'h50 : c;
            if (c >= 21'h460 && c <= 21'h481) return pair_even(c, up);
            if (c >= 21'h48A && c <= 21'h4BF) return pair_even(c, up);
            if (c >= 21'h4C1 && c <= 21'h4CE) return pair_odd(c, up);
            if (c >= 21'h4D0) return pair_even(c, up);
            return c;
        end
        if (c >= 21'h531 && c <= 21'h556) return up ? c : c + 21'h30;
        if (c >= 21'h561 && c <= 21'h586) return up ? c - 21'h30 : c;
        if (c >= 21'hFF21 && c <= 21'hFF3A) return up ? c : c + 21'h20;
        if (c >= 21'hFF41 && c <= 21'hFF5A) return up ? c - 21'h20 : c;
        if (c >= 21'h10400 && c <= 21'h10427) return up ? c : c + 21'h28;
        if (c >= 21'h10428 && c <= 21'h1044F) return up ? c - 21'h28 : c;
        return c;
    endfunction

endpackage

// ===== src/unicode_case_mapper_stream_unit.sv =====
// ----------------------------------------------------------------------------
// unicode_case_mapper_stream_unit
// streaming simple unicode case mapper with upper, lower, title and capitalize
// ----------------------------------------------------------------------------
// s_axis carries one decoded scalar per beat: tdata holds the code point,
// tuser the invalid and string start flags. m_axis returns one beat per input
// beat with the mapped code point and the letter, numeral and cased flags.
// the cfg channel writes the two bit case mode; it is always ready. the user
// must write it only while no beat is in flight; the block does not enforce it.
// throughput is one beat per cycle while the receiver keeps m_axis_tready high.
// a beat is classified on its way into the queue, mapped on its way from the
// queue into the output register and shown on m_axis from that register.
// reset empties the queue and the output register, sets upper case mode and
// marks the next scalar as the start of a word and of a string.
// when the receiver stalls the output register holds its beat, the queue
// fills up to QUEUE_DEPTH beats and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module unicode_case_mapper_stream_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // code_point
    input  logic [1:0]  s_axis_tuser,   // invalid, string_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // mapped_code_point
    output logic [2:0]  m_axis_tuser,   // is_letter, is_num, is_cased
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data      // case_mode
);

    ucm_pkg::t_item front_item;
    ucm_pkg::t_item queue_item;
    logic           queue_full;
    logic           queue_valid;
    logic           queue_pop;
    ucm_pkg::t_cp   mapped_cp;
    logic           is_letter;
    logic           is_num;
    logic           is_cased;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !queue_full;

    ucm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (s_axis_tvalid),
        .i_ready        (s_axis_tready),
        .i_code_point   (s_axis_tdata[20:0]),
        .i_invalid      (s_axis_tuser[0]),
        .i_string_start (s_axis_tuser[1]),
        .o_item         (front_item)
    );

    ucm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    ucm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .i_item       (queue_item),
        .o_pop        (queue_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_code_point (mapped_cp),
        .o_is_letter  (is_letter),
        .o_is_num     (is_num),
        .o_is_cased   (is_cased)
    );

    assign m_axis_tdata = {3'b000, mapped_cp};
    assign m_axis_tuser = {is_cased, is_num, is_letter};

endmodule

// ===== src/ucm_front.sv =====
// ----------------------------------------------------------------------------
// ucm_front
// accepts scalars, classifies them and tracks word and string state
// ----------------------------------------------------------------------------
module ucm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_data,
    input  logic                i_valid,
    input  logic                i_ready,
    input  ucm_pkg::t_cp        i_code_point,
    input  logic                i_invalid,
    input  logic                i_string_start,
    output ucm_pkg::t_item      o_item
);

    ucm_pkg::t_case_mode r_case_mode;
    logic                r_word_start;
    logic                r_first_scalar;
    logic                n_word_start;
    logic                n_first_scalar;

    logic accept;
    logic ws;
    logic fs;
    logic cased;
    logic letter;
    logic digit;
    logic in_word;
    logic up;

    assign accept = i_valid && i_ready;
    assign ws     = i_string_start || r_word_start;
    assign fs     = i_string_start || r_first_scalar;

    always_comb begin
        cased = (ucm_pkg::map_one(i_code_point, 1'b1) != i_code_point)
             || (ucm_pkg::map_one(i_code_point, 1'b0) != i_code_point);
        if (i_code_point < 21'h80) begin
            letter = (i_code_point >= 21'h41 && i_code_point <= 21'h5A)
                  || (i_code_point >= 21'h61 && i_code_point <= 21'h7A);
        end else begin
            letter = cased || ucm_pkg::in_letter(i_code_point);
        end
        digit   = ucm_pkg::in_digit(i_code_point);
        in_word = letter || digit;
        case (r_case_mode)
            ucm_pkg::MODE_UPPER:      up = 1'b1;
            ucm_pkg::MODE_LOWER:      up = 1'b0;
            ucm_pkg::MODE_TITLE:      up = ws && in_word;
            ucm_pkg::MODE_CAPITALIZE: up = fs;
            default:                  up = fs;
        endcase
    end

    always_comb begin
        o_item.code_point = i_code_point;
        o_item.map_en     = !i_invalid;
        o_item.up         = up;
        o_item.is_letter  = letter && !i_invalid;
        o_item.is_num     = digit && !i_invalid;
        o_item.is_cased   = cased && !i_invalid;
    end

    always_comb begin
        n_word_start   = r_word_start;
        n_first_scalar = r_first_scalar;
        if (accept) begin
            n_first_scalar = 1'b0;
            n_word_start   = i_invalid ? 1'b1 : !in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_mode    <= ucm_pkg::MODE_UPPER;
            r_word_start   <= 1'b1;
            r_first_scalar <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_case_mode <= ucm_pkg::t_case_mode'(i_cfg_data);
            end
            r_word_start   <= n_word_start;
            r_first_scalar <= n_first_scalar;
        end
    end

    a_invalid_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_invalid |=> r_word_start && !r_first_scalar)
        else $error("invalid beat did not end the word");

    a_first_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_first_scalar)
        else $error("first scalar flag kept after a beat");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_case_mode == ucm_pkg::t_case_mode'($past(i_cfg_data)))
        else $error("case mode not written");

endmodule

// ===== src/ucm_queue.sv =====
// ----------------------------------------------------------------------------
// ucm_queue
// short register queue between the classifier and the mapping stage
// ----------------------------------------------------------------------------
module ucm_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ucm_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ucm_pkg::t_item o_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    ucm_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(do_push && !do_pop) |-> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(do_pop && !do_push) |-> r_count == $past(r_count) - 1'b1)
        else $error("queue count missed a pop");

endmodule

// ===== src/ucm_back.sv =====
// ----------------------------------------------------------------------------
// ucm_back
// applies the case map and holds the result beat for the receiver
// ----------------------------------------------------------------------------
module ucm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ucm_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output ucm_pkg::t_cp   o_code_point,
    output logic           o_is_letter,
    output logic           o_is_num,
    output logic           o_is_cased
);

    logic         r_valid;
    ucm_pkg::t_cp r_code_point;
    logic         r_is_letter;
    logic         r_is_num;
    logic         r_is_cased;
    ucm_pkg::t_cp n_code_point;

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_comb begin
        n_code_point = i_item.map_en
                     ? ucm_pkg::map_one(i_item.code_point, i_item.up)
                     : i_item.code_point;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code_point <= n_code_point;
            r_is_letter  <= i_item.is_letter;
            r_is_num     <= i_item.is_num;
            r_is_cased   <= i_item.is_cased;
        end
    end

    assign o_valid      = r_valid;
    assign o_code_point = r_code_point;
    assign o_is_letter  = r_is_letter;
    assign o_is_num     = r_is_num;
    assign o_is_cased   = r_is_cased;

endmodule
